@@ design/assert_macros.svh @@
// Assertion macros shared by the sliding window minimum modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define CSW_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sliding window min assertion failed");
// Check that a condition leads to a consequence in the next cycle.
`define CSW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sliding window min assertion failed");
`else
`define CSW_ASSERT(lbl, clk, rst, prop)
`define CSW_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ design/csw_min_pkg.sv @@
// Types and constants shared by the sliding window minimum modules.
package csw_min_pkg;

   // Default sizes
   localparam int DEF_MAX_WINDOW  = 32;
   localparam int DEF_SAMPLE_BITS = 32;

   // Window size register
   localparam int         CFG_W        = 6;
   localparam logic [5:0] WINDOW_RESET = 6'd1;

   // Sequencer states
   typedef enum logic {
      CSW_RUN,
      CSW_REPLAY
   } csw_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic take;   // request accepted this cycle
      logic step;   // wrapped window result produced this cycle
   } csw_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic emit;          // accepted request yields a result
      logic start_replay;  // accepted request opens the wrapped windows
      logic replay_end;    // current wrapped window is the last one
   } csw_status_type;

endpackage

@@ design/circular_sliding_window_min_core.sv @@
// Top level of the circular sliding window minimum block.
//
//   channel   dir  handshake              payload
//   req       in   req_tvalid/req_tready  tdata: sample; tlast: end_of_stream
//   rsp       out  rsp_tvalid/rsp_tready  tdata: window_min; tlast: last_result;
//                                         tuser: too_short
//   csr       in   csr_wr_en              csr_wr_data: window_size
//
// One sample is taken per cycle while intake is open; its result, if any, is valid in the
// cycle after acceptance. The final sample of a stream of at least w samples yields
// its own window's result and then those of the wrapped windows, fed by head store reads.
// Results wait in a single output register; intake stops while that register holds an
// untaken result and while the wrapped windows replay; an output stall pauses the replay.
// The head store needs no clearing pass.
module circular_sliding_window_min_core
   import csw_min_pkg::*;
#(
   parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [CFG_W-1:0]   csr_wr_data,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // sample
   input  logic               req_tlast,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // window_min
   output logic               rsp_tlast,
   output logic               rsp_tuser    // too_short
);

   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   csw_cmd_type                   cmd;
   csw_status_type                status;
   logic [IDX_W-1:0]              replay_idx;
   logic [IDX_W-1:0]              head_rd_idx;
   logic signed [SAMPLE_BITS-1:0] window_min;

   csw_min_ctrl #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .cmd         (cmd),
      .replay_idx  (replay_idx),
      .head_rd_idx (head_rd_idx)
   );

   csw_min_dp #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .sample        (req_tdata[SAMPLE_BITS-1:0]),
      .end_of_stream (req_tlast),
      .cmd           (cmd),
      .replay_idx    (replay_idx),
      .head_rd_idx   (head_rd_idx),
      .status        (status),
      .window_min    (window_min),
      .last_result   (rsp_tlast),
      .too_short     (rsp_tuser)
   );

   // Zero-pad the result to whole bytes
   assign rsp_tdata = TDATA_W'($unsigned(window_min));

endmodule

@@ design/csw_min_ctrl.sv @@
// Sequencer for request intake, wrapped window replay and result valid.
`include "assert_macros.svh"
module csw_min_ctrl
   import csw_min_pkg::*;
#(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  csw_status_type       status,
   output csw_cmd_type          cmd,
   output logic [IDX_W-1:0]     replay_idx,
   output logic [IDX_W-1:0]     head_rd_idx
);

   csw_state_type    state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CSW_RUN: begin
            if (cmd.take && status.start_replay) begin
               state_in = CSW_REPLAY;
            end
         end
         CSW_REPLAY: begin
            if (cmd.step && status.replay_end) begin
               state_in = CSW_RUN;
            end
         end
         default: state_in = CSW_RUN;
      endcase
   end

   // Outputs: handshake, commands and head store read address
   always_comb begin
      req_tready  = 1'b0;
      cmd.take    = 1'b0;
      cmd.step    = 1'b0;
      head_rd_idx = '0;
      unique case (state_ff)
         CSW_RUN: begin
            req_tready = out_free;
            cmd.take   = req_tvalid && out_free;
         end
         CSW_REPLAY: begin
            cmd.step    = out_free;
            // prefetch the next head entry, or hold the current one on a stall
            head_rd_idx = out_free ? idx_ff : idx_ff - IDX_W'(1);
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Advance the replay position
   always_comb begin
      idx_in = idx_ff;
      if (cmd.take) begin
         idx_in = IDX_W'(1);
      end else if (cmd.step) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   // Hold a result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((cmd.take && status.emit) || cmd.step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CSW_RUN;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign replay_idx = idx_ff;

   `CSW_ASSERT(a_no_intake_in_replay, clock, reset, (state_ff != CSW_REPLAY) || !req_tready)
   `CSW_ASSERT(a_replay_idx_nonzero, clock, reset, (state_ff != CSW_REPLAY) || (idx_ff != '0))
   `CSW_ASSERT_NEXT(a_step_gives_result, clock, reset, cmd.step, rsp_valid_ff)
   `CSW_ASSERT_NEXT(a_replay_start, clock, reset, cmd.take && status.start_replay, state_ff == CSW_REPLAY)

endmodule

@@ design/csw_min_dp.sv @@
// Datapath: window size register, running minimum cells, head store, result register.
`include "assert_macros.svh"
module csw_min_dp
   import csw_min_pkg::*;
#(
   parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
   localparam int CNT_W = $clog2(MAX_WINDOW + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [CFG_W-1:0]              csr_wr_data,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          end_of_stream,
   input  csw_cmd_type                   cmd,
   input  logic [IDX_W-1:0]              replay_idx,
   input  logic [IDX_W-1:0]              head_rd_idx,
   output csw_status_type                status,
   output logic signed [SAMPLE_BITS-1:0] window_min,
   output logic                          last_result,
   output logic                          too_short
);

   localparam int WCMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   logic [CFG_W-1:0]              window_ff;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic signed [SAMPLE_BITS-1:0] cells_ff [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] cells_in [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] head_mem [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] head_rd_ff;
   logic signed [SAMPLE_BITS-1:0] hmin_ff, hmin_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic                          last_ff, last_in;
   logic                          short_ff, short_in;
   logic [WCMP_W-1:0]             w_ext;
   logic [CNT_W-1:0]              w_eff;
   logic [CNT_W-1:0]              count_next;
   logic                          is_short;
   logic [CNT_W-1:0]              item_sel;
   logic [CNT_W-1:0]              replay_sel;
   logic signed [SAMPLE_BITS-1:0] tail_min;

   // Window size register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_wr_en) begin
         window_ff <= csr_wr_data;
      end
   end

   // Clamp the window to 1..MAX_WINDOW
   assign w_ext = WCMP_W'(window_ff);
   always_comb begin
      if (w_ext == '0) begin
         w_eff = CNT_W'(1);
      end else if (w_ext > WCMP_W'(MAX_WINDOW)) begin
         w_eff = CNT_W'(MAX_WINDOW);
      end else begin
         w_eff = w_ext[CNT_W-1:0];
      end
   end

   // Cell k holds the minimum of the newest k+1 samples
   always_comb begin
      cells_in[0] = sample;
      for (int k = 1; k < MAX_WINDOW; k++) begin
         cells_in[k] = (sample < cells_ff[k-1]) ? sample : cells_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         cells_ff <= cells_in;
      end
   end

   // Saturating sample count, cleared at end of stream
   assign count_next = (count_ff < CNT_W'(MAX_WINDOW)) ? count_ff + CNT_W'(1) : count_ff;
   assign is_short   = count_next < w_eff;

   always_comb begin
      count_in = count_ff;
      if (cmd.take) begin
         count_in = end_of_stream ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Head store: the first samples of the stream, registered read
   always_ff @(posedge clock) begin
      if (cmd.take && (count_ff < CNT_W'(MAX_WINDOW))) begin
         head_mem[count_ff[IDX_W-1:0]] <= sample;
      end
      head_rd_ff <= head_mem[head_rd_idx];
   end

   // Running minimum over the head entries taken into wrapped windows
   assign hmin_in = (head_rd_ff < hmin_ff) ? head_rd_ff : hmin_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         hmin_ff <= SAMPLE_MAX;
      end else if (cmd.step) begin
         hmin_ff <= hmin_in;
      end
   end

   // Tail part of the current wrapped window
   assign item_sel   = w_eff - CNT_W'(1);
   assign replay_sel = w_eff - CNT_W'(1) - CNT_W'(replay_idx);
   assign tail_min   = cells_ff[replay_sel[IDX_W-1:0]];

   // Select the next result
   always_comb begin
      min_in   = min_ff;
      last_in  = last_ff;
      short_in = short_ff;
      if (cmd.take) begin
         min_in   = is_short ? '0 : cells_in[item_sel[IDX_W-1:0]];
         last_in  = end_of_stream && (is_short || (w_eff == CNT_W'(1)));
         short_in = is_short;
      end else if (cmd.step) begin
         min_in   = (hmin_in < tail_min) ? hmin_in : tail_min;
         last_in  = status.replay_end;
         short_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      min_ff   <= min_in;
      last_ff  <= last_in;
      short_ff <= short_in;
   end

   // Status to the sequencer
   assign status.emit         = end_of_stream || !is_short;
   assign status.start_replay = end_of_stream && !is_short && (w_eff != CNT_W'(1));
   assign status.replay_end   = (CNT_W'(replay_idx) + CNT_W'(1)) == w_eff;

   assign window_min  = min_ff;
   assign last_result = last_ff;
   assign too_short   = short_ff;

   `CSW_ASSERT(a_count_in_range, clock, reset, count_ff <= CNT_W'(MAX_WINDOW))
   `CSW_ASSERT(a_window_in_range, clock, reset, (w_eff != '0) && (w_eff <= CNT_W'(MAX_WINDOW)))
   `CSW_ASSERT_NEXT(a_restart, clock, reset, cmd.take && end_of_stream, count_ff == '0)

endmodule
